@@ rtl/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths, register indexes and control structures of the RGB 2x2
// box downscaler.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int CH_W   = 8;           // one color sample
   localparam int SUM_W  = 9;           // horizontal pair sum of one channel
   localparam int PIX_W  = 3 * CH_W;    // packed red, green, blue
   localparam int PAIR_W = 3 * SUM_W;   // packed pair sums
   localparam int COL_W  = 11;
   localparam int ROW_W  = 12;
   localparam int BX_W   = COL_W - 1;
   localparam int BY_W   = ROW_W - 1;
   localparam int SW_W   = 12;
   localparam int SH_W   = 13;
   localparam int OW_W   = 11;
   localparam int OH_W   = 12;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [SW_W-1:0] SW_MIN   = 12'd2;
   localparam logic [SW_W-1:0] SW_MAX   = 12'd2048;
   localparam logic [SH_W-1:0] SH_MIN   = 13'd2;
   localparam logic [SH_W-1:0] SH_MAX   = 13'd4096;
   localparam logic [OW_W-1:0] OW_MIN   = 11'd1;
   localparam logic [OW_W-1:0] OW_MAX   = 11'd1024;
   localparam logic [OH_W-1:0] OH_MIN   = 12'd1;
   localparam logic [OH_W-1:0] OH_MAX   = 12'd2048;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_OUT_WIDTH     = 2'd2,
      REG_OUT_HEIGHT    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [SW_W-1:0] source_width;
      logic [SH_W-1:0] source_height;
      logic [OW_W-1:0] out_width;
      logic [OH_W-1:0] out_height;
   } cfg_type;

   // Classification of one source pixel, made when the pixel is accepted.
   typedef struct packed {
      logic            odd_col;
      logic            odd_row;
      logic            active;   // block lies inside the effective output size
      logic            last;     // block is the last one of the frame
      logic [BX_W-1:0] bx;
   } item_ctrl_type;

endpackage

@@ rtl/rgb_box_downscale_2x2_top.sv @@
// ----------------------------------------------------------------------------
// rgb_box_downscale_2x2_top
// 2x2 box-filter downscaler for an RGB888 raster stream.
// ----------------------------------------------------------------------------
// Source pixels enter on the req_ stream in raster order, one transaction per
// pixel. Each 2x2 source block gives one output pixel on the rsp_ stream: the
// per-channel sum of the four samples shifted right by two. A result leaves
// with the odd-column pixel of the odd row of its block; rsp_tlast marks the
// last output pixel of a frame. Columns and rows past twice the effective
// output size are cropped and give no transaction.
// The csr_ port holds source width, source height, output width and output
// height; write it only while no transaction is in flight.
// A result passes through the input stage into the output register; the
// input stage holds it while the output register is full and stalled. One
// pixel is accepted every cycle unless a pixel with a result waits; the line
// store is read and written at most once per pixel through separate ports.
// Reset clears the raster counters and the pipeline valids; the line store is
// not cleared, since every entry is written on an even row before it is read.
// When rsp_tready is low, the output register holds its result; pixels without
// a result keep flowing, and req_tready falls once a pixel with a result waits.
// ----------------------------------------------------------------------------
module rgb_box_downscale_2x2_top #(
   parameter int MAX_OUT_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,   // red_in, green_in, blue_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,   // red_out, green_out, blue_out
   output logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rbd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rbd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rbd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int RAM_AW = $clog2(MAX_OUT_WIDTH);

   rbd_pkg::cfg_type                 cfg;
   rbd_pkg::item_ctrl_type           ctrl;
   logic                             accept;
   logic                             wr_en;
   logic [rbd_pkg::BX_W-1:0]         wr_bx;
   logic [rbd_pkg::PAIR_W-1:0]       wr_data;
   logic [rbd_pkg::PAIR_W-1:0]       rd_data;
   logic [RAM_AW-1:0]                wr_addr;
   logic [RAM_AW-1:0]                rd_addr;

   // Block columns in use never reach the store depth, so the column index
   // maps straight onto the address.
   generate
      if (RAM_AW > rbd_pkg::BX_W) begin : g_addr_wide
         assign wr_addr = {{(RAM_AW-rbd_pkg::BX_W){1'b0}}, wr_bx};
         assign rd_addr = {{(RAM_AW-rbd_pkg::BX_W){1'b0}}, ctrl.bx};
      end else begin : g_addr_narrow
         assign wr_addr = wr_bx[RAM_AW-1:0];
         assign rd_addr = ctrl.bx[RAM_AW-1:0];
      end
   endgenerate

   rbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rbd_sequencer #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .accept (accept),
      .ctrl   (ctrl)
   );

   rbd_ram #(
      .WIDTH (rbd_pkg::PAIR_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rbd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .ctrl       (ctrl),
      .accept     (accept),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_bx      (wr_bx),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The input side only stalls behind a full, stalled output register.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output back-pressure");

   // A new result is only loaded when the input stage moves on.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tready))
      else $error("result appeared without a stage advance");

   // The line store is never written at the edge an odd-row read is issued for
   // the same block column of the same row pair.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept && ctrl.odd_row && ctrl.odd_col) |-> (wr_addr != rd_addr))
      else $error("line store read collides with its own write");

endmodule

@@ rtl/rbd_ram.sv @@
// ----------------------------------------------------------------------------
// rbd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rbd_csr.sv @@
// ----------------------------------------------------------------------------
// rbd_csr
// Configuration registers behind an APB-style port: source size and
// requested output size.
// ----------------------------------------------------------------------------
module rbd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rbd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rbd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [rbd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready,
   output rbd_pkg::cfg_type            cfg
);

   rbd_pkg::cfg_type       cfg_ff;
   rbd_pkg::cfg_type       cfg_in;
   rbd_pkg::reg_index_type index;
   logic                   wr_stb;

   assign index      = rbd_pkg::reg_index_type'(csr_paddr[rbd_pkg::CSR_AW-1:2]);
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (index)
            rbd_pkg::REG_SOURCE_WIDTH:
               cfg_in.source_width = csr_pwdata[rbd_pkg::SW_W-1:0];
            rbd_pkg::REG_SOURCE_HEIGHT:
               cfg_in.source_height = csr_pwdata[rbd_pkg::SH_W-1:0];
            rbd_pkg::REG_OUT_WIDTH:
               cfg_in.out_width = csr_pwdata[rbd_pkg::OW_W-1:0];
            rbd_pkg::REG_OUT_HEIGHT:
               cfg_in.out_height = csr_pwdata[rbd_pkg::OH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= rbd_pkg::SW_MAX;
         cfg_ff.source_height <= rbd_pkg::SH_MAX;
         cfg_ff.out_width     <= rbd_pkg::OW_MAX;
         cfg_ff.out_height    <= rbd_pkg::OH_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         rbd_pkg::REG_SOURCE_WIDTH:
            csr_prdata = rbd_pkg::CSR_DW'(cfg_ff.source_width);
         rbd_pkg::REG_SOURCE_HEIGHT:
            csr_prdata = rbd_pkg::CSR_DW'(cfg_ff.source_height);
         rbd_pkg::REG_OUT_WIDTH:
            csr_prdata = rbd_pkg::CSR_DW'(cfg_ff.out_width);
         rbd_pkg::REG_OUT_HEIGHT:
            csr_prdata = rbd_pkg::CSR_DW'(cfg_ff.out_height);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/rbd_sequencer.sv @@
// ----------------------------------------------------------------------------
// rbd_sequencer
// Raster position counters. Classifies each accepted source pixel against
// the effective (clamped) output size and advances column and row.
// ----------------------------------------------------------------------------
module rbd_sequencer #(
   parameter int MAX_OUT_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rbd_pkg::cfg_type       cfg,
   input  logic                   accept,
   output rbd_pkg::item_ctrl_type ctrl
);

   localparam logic [rbd_pkg::OW_W+1:0] MAX_OW = (rbd_pkg::OW_W+2)'(MAX_OUT_WIDTH);

   logic [rbd_pkg::COL_W-1:0] col_ff, col_in;
   logic [rbd_pkg::ROW_W-1:0] row_ff, row_in;

   logic [rbd_pkg::SW_W-1:0]  sw_c;
   logic [rbd_pkg::SH_W-1:0]  sh_c;
   logic [rbd_pkg::OW_W-1:0]  ow_c, ow_e;
   logic [rbd_pkg::OH_W-1:0]  oh_c, oh_e;
   logic [rbd_pkg::COL_W:0]   col_inc;
   logic [rbd_pkg::ROW_W:0]   row_inc;
   logic [rbd_pkg::BX_W-1:0]  bx;
   logic [rbd_pkg::BY_W-1:0]  by;

   // Saturate the registers into their legal ranges.
   always_comb begin
      priority if (cfg.source_width < rbd_pkg::SW_MIN) sw_c = rbd_pkg::SW_MIN;
      else if (cfg.source_width > rbd_pkg::SW_MAX)     sw_c = rbd_pkg::SW_MAX;
      else                                             sw_c = cfg.source_width;

      priority if (cfg.source_height < rbd_pkg::SH_MIN) sh_c = rbd_pkg::SH_MIN;
      else if (cfg.source_height > rbd_pkg::SH_MAX)     sh_c = rbd_pkg::SH_MAX;
      else                                              sh_c = cfg.source_height;

      priority if (cfg.out_width < rbd_pkg::OW_MIN) ow_c = rbd_pkg::OW_MIN;
      else if (cfg.out_width > rbd_pkg::OW_MAX)     ow_c = rbd_pkg::OW_MAX;
      else                                          ow_c = cfg.out_width;

      priority if (cfg.out_height < rbd_pkg::OH_MIN) oh_c = rbd_pkg::OH_MIN;
      else if (cfg.out_height > rbd_pkg::OH_MAX)     oh_c = rbd_pkg::OH_MAX;
      else                                           oh_c = cfg.out_height;
   end

   // The output size never exceeds half the source size; the width never exceeds the line store.
   always_comb begin
      ow_e = ow_c;
      if (sw_c[rbd_pkg::SW_W-1:1] < ow_e) begin
         ow_e = sw_c[rbd_pkg::SW_W-1:1];
      end
      if ({2'b00, ow_e} > MAX_OW) begin
         ow_e = MAX_OW[rbd_pkg::OW_W-1:0];
      end
      oh_e = oh_c;
      if (sh_c[rbd_pkg::SH_W-1:1] < oh_e) begin
         oh_e = sh_c[rbd_pkg::SH_W-1:1];
      end
   end

   assign bx = col_ff[rbd_pkg::COL_W-1:1];
   assign by = row_ff[rbd_pkg::ROW_W-1:1];

   always_comb begin
      ctrl.odd_col = col_ff[0];
      ctrl.odd_row = row_ff[0];
      ctrl.bx      = bx;
      ctrl.active  = ({1'b0, bx} < ow_e) && ({1'b0, by} < oh_e);
      ctrl.last    = ({1'b0, bx} == ow_e - 1'b1) && ({1'b0, by} == oh_e - 1'b1);
   end

   always_comb begin
      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= sw_c) begin
            col_in = '0;
            if (row_inc >= sh_c) begin
               row_in = '0;
            end else begin
               row_in = row_inc[rbd_pkg::ROW_W-1:0];
            end
         end else begin
            col_in = col_inc[rbd_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ rtl/rbd_datapath.sv @@
// ----------------------------------------------------------------------------
// rbd_datapath
// Input stage and result register. Forms horizontal pair sums, writes them
// to the line store on even rows and averages with the stored sums on odd
// rows.
// ----------------------------------------------------------------------------
module rbd_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rbd_pkg::PIX_W-1:0]   req_tdata,
   input  rbd_pkg::item_ctrl_type      ctrl,
   output logic                        accept,
   input  logic [rbd_pkg::PAIR_W-1:0]  rd_data,
   output logic                        wr_en,
   output logic [rbd_pkg::BX_W-1:0]    wr_bx,
   output logic [rbd_pkg::PAIR_W-1:0]  wr_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rbd_pkg::PIX_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [rbd_pkg::PIX_W-1:0]     s1_pix_ff;
   rbd_pkg::item_ctrl_type        s1_ctrl_ff;
   logic [rbd_pkg::PAIR_W-1:0]    pair_ff, pair_in;
   logic                          out_valid_ff, out_valid_in;
   logic [rbd_pkg::PIX_W-1:0]     out_data_ff, out_data_in;
   logic                          out_last_ff, out_last_in;

   logic                          hit;
   logic                          advance;
   logic [rbd_pkg::PAIR_W-1:0]    sum;
   logic [rbd_pkg::PAIR_W-1:0]    fresh;
   logic [rbd_pkg::PIX_W-1:0]     avg;
   logic [rbd_pkg::SUM_W:0]       quad;

   // The stage only waits when it holds a result and the result register is
   // still full.
   assign hit        = s1_valid_ff & s1_ctrl_ff.odd_col & s1_ctrl_ff.active
                       & s1_ctrl_ff.odd_row;
   assign advance    = s1_valid_ff & (~hit | ~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k*rbd_pkg::SUM_W +: rbd_pkg::SUM_W] =
            pair_ff[k*rbd_pkg::SUM_W +: rbd_pkg::SUM_W]
            + rbd_pkg::SUM_W'(s1_pix_ff[k*rbd_pkg::CH_W +: rbd_pkg::CH_W]);
         fresh[k*rbd_pkg::SUM_W +: rbd_pkg::SUM_W] =
            rbd_pkg::SUM_W'(s1_pix_ff[k*rbd_pkg::CH_W +: rbd_pkg::CH_W]);
      end
   end

   always_comb begin
      avg  = '0;
      quad = '0;
      for (int k = 0; k < 3; k++) begin
         quad = (rbd_pkg::SUM_W+1)'(rd_data[k*rbd_pkg::SUM_W +: rbd_pkg::SUM_W])
                + (rbd_pkg::SUM_W+1)'(sum[k*rbd_pkg::SUM_W +: rbd_pkg::SUM_W]);
         avg[k*rbd_pkg::CH_W +: rbd_pkg::CH_W] = quad[rbd_pkg::SUM_W:2];
      end
   end

   assign wr_en   = advance & s1_ctrl_ff.odd_col & s1_ctrl_ff.active & ~s1_ctrl_ff.odd_row;
   assign wr_bx   = s1_ctrl_ff.bx;
   assign wr_data = sum;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      pair_in      = pair_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
         if (~s1_ctrl_ff.odd_col) begin
            pair_in = fresh;
         end else if (s1_ctrl_ff.active) begin
            pair_in = sum;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
      if (advance & hit) begin
         out_valid_in = 1'b1;
         out_data_in  = avg;
         out_last_in  = s1_ctrl_ff.last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pair_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         pair_ff      <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_ctrl_ff <= ctrl;
      end
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ tb/tb_rgb_box_downscale_2x2_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_box_downscale_2x2_top
// Self-checking testbench of the RGB 2x2 box downscaler.
// ----------------------------------------------------------------------------
// Whole source frames are streamed in under a series of register settings:
// a short patterned part, small random frames, and a wide and a tall frame,
// with register values below and above the legal ranges. A built-in
// model of the raster counters and the line store predicts every averaged
// output pixel, and each received transaction is compared field by field.
// Both stream sides idle and stall at random. Registers change only between
// frames, once the block has drained.
// ----------------------------------------------------------------------------
module tb_rgb_box_downscale_2x2_top;

   localparam int          MAX_OUT_WIDTH  = 1024;
   localparam int unsigned CYCLE_LIMIT    = 3_000_000;
   localparam int unsigned RANDOM_PIXELS  = 440;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef struct packed {
      logic                     last;
      logic [rbd_pkg::CH_W-1:0] blue;
      logic [rbd_pkg::CH_W-1:0] green;
      logic [rbd_pkg::CH_W-1:0] red;
   } block_avg_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [rbd_pkg::PIX_W-1:0]  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [rbd_pkg::PIX_W-1:0]  rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [rbd_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [rbd_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [rbd_pkg::CSR_DW-1:0] csr_prdata;
   logic                       csr_pready;

   rgb_box_downscale_2x2_top #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Stimulus and scoreboard.
   logic [rbd_pkg::PIX_W-1:0] pixel_queue[$];
   block_avg_type    expected_blocks[$];
   int unsigned      pushed_pixels = 0;
   int unsigned      accepted_pixels = 0;
   int unsigned      results_seen = 0;
   int unsigned      mismatches = 0;
   int unsigned      cycle_count = 0;
   int unsigned      send_gap = 0;
   int unsigned      send_calm = 0;
   int unsigned      recv_hold = 0;
   int unsigned      recv_calm = 0;

   // Model state: register copies, raster position and line store.
   logic [rbd_pkg::SW_W-1:0]       src_w_reg = rbd_pkg::SW_MAX;
   logic [rbd_pkg::SH_W-1:0]       src_h_reg = rbd_pkg::SH_MAX;
   logic [rbd_pkg::OW_W-1:0]       out_w_reg = rbd_pkg::OW_MAX;
   logic [rbd_pkg::OH_W-1:0]       out_h_reg = rbd_pkg::OH_MAX;
   int unsigned                    col_pos = 0;
   int unsigned                    row_pos = 0;
   logic [2:0][rbd_pkg::SUM_W-1:0] pair_acc = '0;
   logic [2:0][rbd_pkg::SUM_W-1:0] line_store[MAX_OUT_WIDTH];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Effective source size and output size after saturation and clamping.
   function automatic void effective_size(input logic [rbd_pkg::SW_W-1:0] swr,
                                          input logic [rbd_pkg::SH_W-1:0] shr,
                                          input logic [rbd_pkg::OW_W-1:0] owr,
                                          input logic [rbd_pkg::OH_W-1:0] ohr,
                                          output int unsigned sw, output int unsigned sh,
                                          output int unsigned ow, output int unsigned oh);
      sw = clamp_to(swr, rbd_pkg::SW_MIN, rbd_pkg::SW_MAX);
      sh = clamp_to(shr, rbd_pkg::SH_MIN, rbd_pkg::SH_MAX);
      ow = clamp_to(owr, rbd_pkg::OW_MIN, rbd_pkg::OW_MAX);
      oh = clamp_to(ohr, rbd_pkg::OH_MIN, rbd_pkg::OH_MAX);
      if (ow > sw / 2) ow = sw / 2;
      if (ow > MAX_OUT_WIDTH) ow = MAX_OUT_WIDTH;
      if (oh > sh / 2) oh = sh / 2;
   endfunction

   // Advances the raster model by one source pixel and queues the averaged
   // block when the pixel closes one.
   function automatic void box_filter_step(input logic [rbd_pkg::PIX_W-1:0] pix);
      logic [2:0][rbd_pkg::CH_W-1:0]  px;
      logic [2:0][rbd_pkg::SUM_W-1:0] sum;
      logic [2:0][rbd_pkg::CH_W-1:0]  mean;
      logic [rbd_pkg::SUM_W:0]        total;
      int unsigned                    sw, sh, ow, oh, bx, by;
      int                             k;
      px = pix;
      effective_size(src_w_reg, src_h_reg, out_w_reg, out_h_reg, sw, sh, ow, oh);
      bx = col_pos >> 1;
      by = row_pos >> 1;
      if (col_pos % 2 == 0) begin
         for (k = 0; k < 3; k++) pair_acc[k] = {1'b0, px[k]};
      end else if (bx < ow && by < oh) begin
         for (k = 0; k < 3; k++) sum[k] = pair_acc[k] + rbd_pkg::SUM_W'(px[k]);
         pair_acc = sum;
         if (row_pos % 2 == 0) begin
            line_store[bx % MAX_OUT_WIDTH] = sum;
         end else begin
            for (k = 0; k < 3; k++) begin
               total = {1'b0, line_store[bx % MAX_OUT_WIDTH][k]} + {1'b0, sum[k]};
               mean[k] = total[rbd_pkg::SUM_W:2];
            end
            expected_blocks.push_back({(bx == ow - 1 && by == oh - 1), mean[2], mean[1],
                                       mean[0]});
         end
      end
      col_pos++;
      if (col_pos >= sw) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= sh) row_pos = 0;
      end
   endfunction

   // Per-transaction wait, with occasional runs of back-to-back traffic.
   function automatic int unsigned pick_wait(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [rbd_pkg::PIX_W-1:0] random_pixel();
      logic [2:0][rbd_pkg::CH_W-1:0] px;
      int                            k;
      for (k = 0; k < 3; k++) begin
         case ($urandom_range(0, 5))
            0: px[k] = 8'h00;
            1: px[k] = 8'hFF;
            default: px[k] = rbd_pkg::CH_W'($urandom);
         endcase
      end
      return px;
   endfunction

   function automatic void report_mismatch(input string what, input int unsigned exp_v,
                                           input int unsigned act_v);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch in %s of output pixel %0d: expected %0h, got %0h",
                  what, results_seen, exp_v, act_v);
   endfunction

   // Source pixel driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_queue.pop_front();
            send_gap = pick_wait(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Output sink with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         recv_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) recv_hold = pick_wait(recv_calm);
         else if (recv_hold != 0) recv_hold--;
         rsp_tready <= (recv_hold == 0);
      end
   end

   // Monitor: register writes, accepted pixels and output pixels.
   always @(posedge clock) begin
      block_avg_type exp_blk;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (rbd_pkg::reg_index_type'(csr_paddr[3:2]))
               rbd_pkg::REG_SOURCE_WIDTH:  src_w_reg = csr_pwdata[rbd_pkg::SW_W-1:0];
               rbd_pkg::REG_SOURCE_HEIGHT: src_h_reg = csr_pwdata[rbd_pkg::SH_W-1:0];
               rbd_pkg::REG_OUT_WIDTH:     out_w_reg = csr_pwdata[rbd_pkg::OW_W-1:0];
               rbd_pkg::REG_OUT_HEIGHT:    out_h_reg = csr_pwdata[rbd_pkg::OH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            accepted_pixels++;
            box_filter_step(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected transaction (data)", 0, rsp_tdata);
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_tdata[7:0] !== exp_blk.red)
                  report_mismatch("red", exp_blk.red, rsp_tdata[7:0]);
               if (rsp_tdata[15:8] !== exp_blk.green)
                  report_mismatch("green", exp_blk.green, rsp_tdata[15:8]);
               if (rsp_tdata[23:16] !== exp_blk.blue)
                  report_mismatch("blue", exp_blk.blue, rsp_tdata[23:16]);
               if (rsp_tlast !== exp_blk.last)
                  report_mismatch("frame_last", exp_blk.last, rsp_tlast);
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rgb_box_downscale_2x2_top] ERROR");
         $finish;
      end
   end

   task automatic csr_write(input rbd_pkg::reg_index_type idx,
                            input logic [rbd_pkg::CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Holds off until every pixel is taken and every output pixel has come,
   // then lets the pipeline settle for cropped pixels still in flight.
   task automatic wait_drained();
      while (accepted_pixels != pushed_pixels || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Programs one setting and queues whole frames, so the line store is
   // always refilled on an even row before it is read.
   task automatic run_frames(input logic [rbd_pkg::CSR_DW-1:0] sw_v,
                             input logic [rbd_pkg::CSR_DW-1:0] sh_v,
                             input logic [rbd_pkg::CSR_DW-1:0] ow_v,
                             input logic [rbd_pkg::CSR_DW-1:0] oh_v,
                             input int unsigned frames, input bit patterned,
                             output int unsigned queued);
      int unsigned sw, sh, ow, oh, i;
      wait_drained();
      csr_write(rbd_pkg::REG_SOURCE_WIDTH, sw_v);
      csr_write(rbd_pkg::REG_SOURCE_HEIGHT, sh_v);
      csr_write(rbd_pkg::REG_OUT_WIDTH, ow_v);
      csr_write(rbd_pkg::REG_OUT_HEIGHT, oh_v);
      effective_size(sw_v[rbd_pkg::SW_W-1:0], sh_v[rbd_pkg::SH_W-1:0],
                     ow_v[rbd_pkg::OW_W-1:0], oh_v[rbd_pkg::OH_W-1:0],
                     sw, sh, ow, oh);
      queued = frames * sw * sh;
      for (i = 0; i < queued; i++) begin
         if (!patterned) pixel_queue.push_back(random_pixel());
         else begin
            case (i % 4)
               0: pixel_queue.push_back(24'hFFFFFF);
               1: pixel_queue.push_back(24'h000000);
               2: pixel_queue.push_back(24'h80FF01);
               default: pixel_queue.push_back(24'h7F00FE);
            endcase
         end
         pushed_pixels++;
      end
   endtask

   initial begin
      int unsigned random_pixels, queued;
      logic [rbd_pkg::CSR_DW-1:0] sw_v, sh_v, ow_v, oh_v;
      random_pixels = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Cropped last columns and rows, oversized output height.
      run_frames(5, 3, 1, 7, 1, 1'b1, queued);
      // Every register below its range: the smallest 2x2 frame.
      run_frames(1, 0, 0, 0, 1, 1'b1, queued);

      // A wide frame, then a tall one, each with out-of-range register values.
      run_frames(160, 1, 1024, 4095, 1, 1'b0, queued);
      run_frames(0, 120, 2047, 2048, 1, 1'b0, queued);

      while (random_pixels < RANDOM_PIXELS) begin
         sw_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
         sh_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
         case ($urandom_range(0, 5))
            0: ow_v = 0;
            1: ow_v = $urandom_range(1025, 2047);
            2: ow_v = rbd_pkg::OW_MAX;
            default: ow_v = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 5))
            0: oh_v = 0;
            1: oh_v = $urandom_range(2049, 4095);
            2: oh_v = rbd_pkg::OH_MAX;
            default: oh_v = $urandom_range(1, 6);
         endcase
         run_frames(sw_v, sh_v, ow_v, oh_v, $urandom_range(1, 2), 1'b0, queued);
         random_pixels += queued;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("[rgb_box_downscale_2x2_top] OK");
      end else begin
         $display("[rgb_box_downscale_2x2_top] ERROR");
      end
      $finish;
   end

endmodule
